FILE: rtl/lu8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lu8d_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;

    // Byte class tags, compared against the top bits of a byte.
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Continuations needed for each lead form.
    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              end_of_text;
    } t_in;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last_of_run;
    } t_out;

    // One input word's worth of results: up to three raw flush bytes
    // (lead, then continuations) followed by an optional final code point.
    typedef struct packed {
        logic [2:0][BYTE_W-1:0] raw;
        logic [1:0]             raw_cnt;
        logic                   tail_en;
        logic [CP_W-1:0]        tail;
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/lenient_utf8_decoder.sv
// A word's job is written into the job queue, then into the back end's job register,
// from which its first result is presented; a busy back end holds the job in the queue.
// Throughput: one input word per cycle while each word yields at most one result and the
// output is taken; a word that yields k results (k up to 4) presents them one at a time,
// and the two-entry job queue absorbs the difference before the input stalls.
// Reset (i_rst_n, synchronous, active low) closes any open sequence and empties the
// queue and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module lenient_utf8_decoder (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lu8d_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output lu8d_pkg::t_out     o_out
);

    // Front end: classify each byte, track the open sequence, and turn the
    // word into one job listing every result it causes.
    logic           push;
    logic           q_full;
    lu8d_pkg::t_job push_job;

    // Queue to back end.
    logic           q_valid;
    logic           pop;
    lu8d_pkg::t_job q_job;

    lu8d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Short job queue: lets the front keep accepting while the back end
    // is still unrolling a multi-result flush.
    lu8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // Back end: hold one job and emit its results one per handshake,
    // marking the final one.
    lu8d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: rtl/lu8d_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lu8d_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lu8d_pkg::t_in i_in,
    input  wire logic          i_q_full,
    output logic               o_push,
    output lu8d_pkg::t_job     o_job
);

    logic [7:0]  r_lead, n_lead;
    logic [7:0]  r_cont [2];
    logic [20:0] r_accum, n_accum;
    logic [1:0]  r_need, n_need;
    logic [1:0]  r_have, n_have;
    logic        cont_wr;

    logic [7:0]  b;
    logic        eot;
    logic        accept;
    logic        is_cont;
    logic        seq_open;
    logic        fresh;
    logic [1:0]  have_inc;
    logic [20:0] acc_shift;
    logic [1:0]  lead_need;
    logic [20:0] lead_bits;
    lu8d_pkg::t_job job;

    assign b        = i_in.byte_in;
    assign eot      = i_in.end_of_text;
    assign o_in_ready = !i_q_full;
    assign accept   = i_in_valid && o_in_ready;
    assign is_cont  = (b[7:6] == lu8d_pkg::CONT_TAG);
    assign seq_open = (r_need != lu8d_pkg::NEED_NONE);
    assign have_inc = r_have + 2'd1;
    assign acc_shift = {r_accum[14:0], b[5:0]};

    always_comb begin
        lead_need = lu8d_pkg::NEED_NONE;
        lead_bits = '0;
        if (b[7:5] == lu8d_pkg::LEAD2_TAG) begin
            lead_need = lu8d_pkg::NEED_ONE;
            lead_bits = {16'd0, b[4:0]};
        end else if (b[7:4] == lu8d_pkg::LEAD3_TAG) begin
            lead_need = lu8d_pkg::NEED_TWO;
            lead_bits = {17'd0, b[3:0]};
        end else if (b[7:3] == lu8d_pkg::LEAD4_TAG) begin
            lead_need = lu8d_pkg::NEED_THREE;
            lead_bits = {18'd0, b[2:0]};
        end
    end

    always_comb begin
        n_lead  = r_lead;
        n_accum = r_accum;
        n_need  = r_need;
        n_have  = r_have;
        cont_wr = 1'b0;
        fresh   = 1'b1;
        job.raw[0]  = r_lead;
        job.raw[1]  = r_cont[0];
        job.raw[2]  = r_cont[1];
        job.raw_cnt = 2'd0;
        job.tail_en = 1'b0;
        job.tail    = '0;

        if (seq_open) begin
            if (is_cont) begin
                fresh = 1'b0;
                if (have_inc >= r_need) begin
                    // sequence complete: emit the code point, close
                    job.tail_en = 1'b1;
                    job.tail    = acc_shift;
                    n_lead  = '0;
                    n_accum = '0;
                    n_need  = lu8d_pkg::NEED_NONE;
                    n_have  = 2'd0;
                end else if (eot) begin
                    // flush lead and continuations, this byte included
                    if (r_have == 2'd0) begin
                        job.raw[1] = b;
                    end else begin
                        job.raw[2] = b;
                    end
                    job.raw_cnt = have_inc + 2'd1;
                    n_lead  = '0;
                    n_accum = '0;
                    n_need  = lu8d_pkg::NEED_NONE;
                    n_have  = 2'd0;
                end else begin
                    cont_wr = 1'b1;
                    n_accum = acc_shift;
                    n_have  = have_inc;
                end
            end else begin
                // interrupted: flush what was taken so far
                job.raw_cnt = r_have + 2'd1;
                n_lead  = '0;
                n_accum = '0;
                n_need  = lu8d_pkg::NEED_NONE;
                n_have  = 2'd0;
            end
        end

        if (fresh) begin
            if (!b[7]) begin
                job.tail_en = 1'b1;
                job.tail    = {13'd0, b};
            end else if (lead_need != lu8d_pkg::NEED_NONE) begin
                if (eot) begin
                    // lone lead at end of text goes out raw
                    job.tail_en = 1'b1;
                    job.tail    = {13'd0, b};
                end else begin
                    n_lead  = b;
                    n_accum = lead_bits;
                    n_need  = lead_need;
                    n_have  = 2'd0;
                end
            end else begin
                job.tail_en = 1'b1;
                job.tail    = {13'd0, b};
            end
        end
    end

    assign o_push = accept && ((job.raw_cnt != 2'd0) || job.tail_en);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= '0;
            r_accum <= '0;
            r_need  <= lu8d_pkg::NEED_NONE;
            r_have  <= 2'd0;
        end else if (accept) begin
            r_lead  <= n_lead;
            r_accum <= n_accum;
            r_need  <= n_need;
            r_have  <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && cont_wr) begin
            r_cont[r_have[0]] <= b;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lu8d_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lu8d_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lu8d_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output lu8d_pkg::t_job      o_job
);

    lu8d_pkg::t_job r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lu8d_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lu8d_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire lu8d_pkg::t_job i_q_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output lu8d_pkg::t_out      o_out
);

    logic           r_busy;
    lu8d_pkg::t_job r_job;
    logic [1:0]     r_pos;
    logic [2:0]     total;
    logic           last;
    logic           take;

    assign total = {1'b0, r_job.raw_cnt} + {2'd0, r_job.tail_en};
    assign last  = ({1'b0, r_pos} + 3'd1) == total;
    assign take  = r_busy && i_out_ready;
    assign o_pop = i_q_valid && (!r_busy || (take && last));

    assign o_out_valid = r_busy;

    always_comb begin
        o_out.last_of_run = last;
        if (r_pos < r_job.raw_cnt) begin
            case (r_pos)
                2'd0:    o_out.code_point = {13'd0, r_job.raw[0]};
                2'd1:    o_out.code_point = {13'd0, r_job.raw[1]};
                default: o_out.code_point = {13'd0, r_job.raw[2]};
            endcase
        end else begin
            o_out.code_point = r_job.tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_pos  <= 2'd0;
        end else if (take) begin
            // advance through the job; drop busy after its last result
            if (last) begin
                r_busy <= 1'b0;
                r_pos  <= 2'd0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire
